// File: hw/rtl/rbol_pkg.sv
// ----------------------------------------------------------------------------
// Ring buffer offset lookup: shared package
// Sizes, command codes, sequencer states and the slot store port types.
// ----------------------------------------------------------------------------
package rbol_pkg;

  // Ring geometry and field widths
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned HDL_W  = 32;
  localparam int unsigned TOT_W  = 20;
  localparam int unsigned SIZE_W = 16;

  // Command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD_EVICT,
    ST_ADD_SUM,
    ST_FIND
  } rbol_state_e;

  // Write request into the slot store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [HDL_W-1:0] handle;
    logic [LEN_W-1:0] len;
  } slot_wr_t;

  // Registered read data from the slot store
  typedef struct packed {
    logic [HDL_W-1:0] handle;
    logic [LEN_W-1:0] len;
  } slot_rd_t;

  // Advance a ring index with wrap
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    return r;
  endfunction

endpackage

// File: hw/rtl/rbol_slot_store.sv
// ----------------------------------------------------------------------------
// Ring buffer offset lookup: slot store
// Handle and length memories, one write and one registered read per cycle.
// Lengths read as zero until their slot is first written.
// ----------------------------------------------------------------------------
module rbol_slot_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rbol_pkg::IDX_W-1:0]     rd_addr_i,
  input  rbol_pkg::slot_wr_t             wr_i,
  output rbol_pkg::slot_rd_t             rd_o
);

  logic [rbol_pkg::HDL_W-1:0] hdl_mem [rbol_pkg::DEPTH];
  logic [rbol_pkg::LEN_W-1:0] len_mem [rbol_pkg::DEPTH];
  logic [rbol_pkg::DEPTH-1:0] len_vld_q;
  logic                       rd_vld_q;
  logic [rbol_pkg::LEN_W-1:0] rd_len_q;
  logic [rbol_pkg::HDL_W-1:0] rd_hdl_q;

  // Mark slots that hold a written length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= len_vld_q[rd_addr_i];
      if (wr_i.en) begin
        len_vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  // Write and read the memories
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      hdl_mem[wr_i.addr] <= wr_i.handle;
      len_mem[wr_i.addr] <= wr_i.len;
    end
    rd_hdl_q <= hdl_mem[rd_addr_i];
    rd_len_q <= len_mem[rd_addr_i];
  end

  // Mask lengths of never-written slots
  assign rd_o.handle = rd_hdl_q;
  assign rd_o.len    = rd_vld_q ? rd_len_q : '0;

endmodule

// File: hw/rtl/ring_buffer_offset_lookup_unit.sv
// ----------------------------------------------------------------------------
// Ring buffer offset lookup unit
// Overwrite-oldest ring of record handles and lengths with a running byte
// total and a walk that maps a byte offset to its slot.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Payload
//  --------  -----------------------  ---------------------------------------
//  request   start_i, busy_o          cmd_i, entry_size_i, entry_handle_i,
//                                     char_offset_i
//  result    done_o (one-cycle pulse) found_o, slot_index_o, found_handle_o,
//                                     byte_in_entry_o, evicted_valid_o,
//                                     evicted_handle_o, total_bytes_o
//
// A request is taken when start_i is high and busy_o is low.
// An add passes through the evict and sum states before done_o; a find
// walks one slot per cycle through the shared subtractor, paced by the
// single read port of the slot store.
// Reset clears indices, the byte total and all slot lengths at once.
// Results are shown for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
module ring_buffer_offset_lookup_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cmd_i,
  input  logic [rbol_pkg::SIZE_W-1:0]   entry_size_i,
  input  logic [rbol_pkg::HDL_W-1:0]    entry_handle_i,
  input  logic [rbol_pkg::TOT_W-1:0]    char_offset_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [rbol_pkg::IDX_W-1:0]    slot_index_o,
  output logic [rbol_pkg::HDL_W-1:0]    found_handle_o,
  output logic [rbol_pkg::LEN_W-1:0]    byte_in_entry_o,
  output logic                          evicted_valid_o,
  output logic [rbol_pkg::HDL_W-1:0]    evicted_handle_o,
  output logic [rbol_pkg::TOT_W-1:0]    total_bytes_o
);

  rbol_pkg::rbol_state_e state_q, state_d;

  logic [rbol_pkg::IDX_W-1:0] wr_idx_q, rd_idx_q, pos_q, cnt_q;
  logic                       full_q;
  logic [rbol_pkg::TOT_W-1:0] total_q, remain_q;
  logic [rbol_pkg::LEN_W-1:0] size_q;
  logic [rbol_pkg::HDL_W-1:0] handle_q, ev_hdl_q;
  logic                       ev_vld_q;

  // Result registers
  logic                       done_q, found_q, res_ev_vld_q;
  logic [rbol_pkg::IDX_W-1:0] res_slot_q;
  logic [rbol_pkg::HDL_W-1:0] res_fhdl_q, res_ev_hdl_q;
  logic [rbol_pkg::LEN_W-1:0] res_inb_q;
  logic [rbol_pkg::TOT_W-1:0] res_total_q;

  logic                       accept;
  logic [rbol_pkg::IDX_W-1:0] rd_addr;
  rbol_pkg::slot_wr_t         slot_wr;
  rbol_pkg::slot_rd_t         slot_rd;

  // Shared add/subtract unit
  logic [rbol_pkg::TOT_W-1:0] alu_a, alu_b;
  logic                       alu_sub;
  logic [rbol_pkg::TOT_W:0]   alu_sum;
  logic                       alu_borrow;

  // Sequencer controls
  logic last_slot, find_hit, find_miss, find_step;
  logic evict_ld, add_done;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != rbol_pkg::ST_IDLE);

  rbol_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_i      (slot_wr),
    .rd_o      (slot_rd)
  );

  // Add or subtract; carry out of the top bit is clear on a borrow
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{rbol_pkg::TOT_W{1'b0}}, alu_sub};
  assign alu_borrow = alu_sub && !alu_sum[rbol_pkg::TOT_W];

  assign last_slot = (cnt_q == rbol_pkg::IDX_W'(rbol_pkg::DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbol_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (cmd_i == rbol_pkg::CMD_FIND) ? rbol_pkg::ST_FIND
                                                  : rbol_pkg::ST_ADD_EVICT;
        end
      end
      rbol_pkg::ST_ADD_EVICT: state_d = rbol_pkg::ST_ADD_SUM;
      rbol_pkg::ST_ADD_SUM:   state_d = rbol_pkg::ST_IDLE;
      rbol_pkg::ST_FIND: begin
        if (find_hit || find_miss) begin
          state_d = rbol_pkg::ST_IDLE;
        end
      end
      default: state_d = rbol_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls per state
  always_comb begin
    alu_a          = total_q;
    alu_b          = {{(rbol_pkg::TOT_W - rbol_pkg::LEN_W){1'b0}}, slot_rd.len};
    alu_sub        = 1'b0;
    slot_wr.en     = 1'b0;
    slot_wr.addr   = wr_idx_q;
    slot_wr.handle = handle_q;
    slot_wr.len    = size_q;
    rd_addr        = (cmd_i == rbol_pkg::CMD_FIND) ? rd_idx_q : wr_idx_q;
    evict_ld       = 1'b0;
    add_done       = 1'b0;
    find_hit       = 1'b0;
    find_miss      = 1'b0;
    find_step      = 1'b0;
    unique case (state_q)
      rbol_pkg::ST_IDLE: begin
      end
      rbol_pkg::ST_ADD_EVICT: begin
        // when full, drop the oldest length from the total; write the new record
        alu_sub    = 1'b1;
        evict_ld   = 1'b1;
        slot_wr.en = 1'b1;
      end
      rbol_pkg::ST_ADD_SUM: begin
        alu_b    = {{(rbol_pkg::TOT_W - rbol_pkg::LEN_W){1'b0}}, size_q};
        add_done = 1'b1;
      end
      rbol_pkg::ST_FIND: begin
        // compare remaining offset against this slot, prefetch the next
        alu_a     = remain_q;
        alu_sub   = 1'b1;
        rd_addr   = rbol_pkg::next_idx(pos_q);
        find_hit  = alu_borrow;
        find_miss = !alu_borrow && last_slot;
        find_step = !alu_borrow && !last_slot;
      end
      default: begin
      end
    endcase
  end

  // State and ring bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rbol_pkg::ST_IDLE;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      full_q   <= 1'b0;
      total_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= add_done || find_hit || find_miss;
      if (evict_ld && full_q) begin
        total_q  <= alu_sum[rbol_pkg::TOT_W-1:0];
        rd_idx_q <= rbol_pkg::next_idx(rd_idx_q);
      end
      if (add_done) begin
        total_q  <= alu_sum[rbol_pkg::TOT_W-1:0];
        wr_idx_q <= rbol_pkg::next_idx(wr_idx_q);
        full_q   <= (rbol_pkg::next_idx(wr_idx_q) == rd_idx_q);
      end
    end
  end

  // Request capture, walk registers and results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q   <= entry_size_i;
      handle_q <= entry_handle_i;
      remain_q <= char_offset_i;
      pos_q    <= rd_idx_q;
      cnt_q    <= '0;
    end
    if (evict_ld) begin
      ev_vld_q <= full_q;
      ev_hdl_q <= full_q ? slot_rd.handle : '0;
    end
    if (find_step) begin
      remain_q <= alu_sum[rbol_pkg::TOT_W-1:0];
      pos_q    <= rbol_pkg::next_idx(pos_q);
      cnt_q    <= cnt_q + 1'b1;
    end
    if (add_done) begin
      found_q      <= 1'b0;
      res_slot_q   <= '0;
      res_fhdl_q   <= '0;
      res_inb_q    <= '0;
      res_ev_vld_q <= ev_vld_q;
      res_ev_hdl_q <= ev_hdl_q;
      res_total_q  <= alu_sum[rbol_pkg::TOT_W-1:0];
    end
    if (find_hit || find_miss) begin
      found_q      <= find_hit;
      res_slot_q   <= find_hit ? pos_q : '0;
      res_fhdl_q   <= find_hit ? slot_rd.handle : '0;
      res_inb_q    <= find_hit ? remain_q[rbol_pkg::LEN_W-1:0] : '0;
      res_ev_vld_q <= 1'b0;
      res_ev_hdl_q <= '0;
      res_total_q  <= total_q;
    end
  end

  assign done_o           = done_q;
  assign found_o          = found_q;
  assign slot_index_o     = res_slot_q;
  assign found_handle_o   = res_fhdl_q;
  assign byte_in_entry_o  = res_inb_q;
  assign evicted_valid_o  = res_ev_vld_q;
  assign evicted_handle_o = res_ev_hdl_q;
  assign total_bytes_o    = res_total_q;

  // A result always follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy_o))
    else $error("result pulse without a request in flight");

  // Accepted requests occupy the unit
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o)
    else $error("unit not busy after accepting a request");

  // A full ring has meeting indices between requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (full_q && !busy_o) |-> (wr_idx_q == rd_idx_q))
    else $error("ring full with separate read and write indices");

  // Find and evict never report together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> !(found_o && evicted_valid_o))
    else $error("find and evict flagged in one result");

endmodule

// File: tb/sv/tb_ring_buffer_offset_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer offset lookup unit: self-checking testbench
// A short table of directed requests walks the empty, full and wrap-around
// cases, then random adds and finds run under several sender idle rates.
// A local copy of the ring state predicts every response; each done_o pulse
// is checked field by field against the oldest predicted response.
// ----------------------------------------------------------------------------
module tb_ring_buffer_offset_lookup_unit;

  localparam int unsigned DIR_N          = 25;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // One response of the block
  typedef struct packed {
    logic                       found;
    logic [rbol_pkg::IDX_W-1:0] slot;
    logic [rbol_pkg::HDL_W-1:0] fhandle;
    logic [rbol_pkg::LEN_W-1:0] in_byte;
    logic                       ev_valid;
    logic [rbol_pkg::HDL_W-1:0] ev_handle;
    logic [rbol_pkg::TOT_W-1:0] total;
  } lookup_result_t;

  // One row of the directed table
  typedef struct {
    logic                        cmd;
    logic [rbol_pkg::SIZE_W-1:0] size;
    logic [rbol_pkg::HDL_W-1:0]  handle;
    logic [rbol_pkg::TOT_W-1:0]  offset;
    bit                          typed;
    lookup_result_t              want;
  } directed_row_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        start_i        = 1'b0;
  logic                        busy_o;
  logic                        cmd_i          = rbol_pkg::CMD_ADD;
  logic [rbol_pkg::SIZE_W-1:0] entry_size_i   = '0;
  logic [rbol_pkg::HDL_W-1:0]  entry_handle_i = '0;
  logic [rbol_pkg::TOT_W-1:0]  char_offset_i  = '0;
  logic                        done_o;
  logic                        found_o;
  logic [rbol_pkg::IDX_W-1:0]  slot_index_o;
  logic [rbol_pkg::HDL_W-1:0]  found_handle_o;
  logic [rbol_pkg::LEN_W-1:0]  byte_in_entry_o;
  logic                        evicted_valid_o;
  logic [rbol_pkg::HDL_W-1:0]  evicted_handle_o;
  logic [rbol_pkg::TOT_W-1:0]  total_bytes_o;

  // Local copy of the ring
  logic [rbol_pkg::HDL_W-1:0] ring_handles [rbol_pkg::DEPTH] = '{default: '0};
  logic [rbol_pkg::LEN_W-1:0] ring_lens    [rbol_pkg::DEPTH] = '{default: '0};
  logic [rbol_pkg::IDX_W-1:0] ring_wr      = '0;
  logic [rbol_pkg::IDX_W-1:0] ring_rd      = '0;
  logic                       ring_is_full = 1'b0;
  logic [rbol_pkg::TOT_W-1:0] ring_total   = '0;

  lookup_result_t due_responses [$];
  int unsigned    mismatch_count = 0;
  int unsigned    quiet_cycles   = 0;
  int unsigned    idle_pct       = 0;

  // Directed requests; the expected response is typed in where obvious
  directed_row_t dir_rows [DIR_N] = '{
    // find on the empty ring
    '{rbol_pkg::CMD_FIND, 16'h0000, 32'h0000_0000, 20'h00000, 1'b1,
      '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 32'h0, 20'h00000}},
    // zero-length add, then the largest record
    '{rbol_pkg::CMD_ADD, 16'h0000, 32'h0000_0000, 20'h00000, 1'b1,
      '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 32'h0, 20'h00000}},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 20'h00000, 1'b1,
      '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 32'h0, 20'h0FFFF}},
    // the empty slot is skipped; first, last and one past the last byte
    '{rbol_pkg::CMD_FIND, 16'h0000, 32'h0000_0000, 20'h00000, 1'b1,
      '{1'b1, 4'd1, 32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0, 20'h0FFFF}},
    '{rbol_pkg::CMD_FIND, 16'hFFFF, 32'hFFFF_FFFF, 20'h0FFFE, 1'b1,
      '{1'b1, 4'd1, 32'hFFFF_FFFF, 16'hFFFE, 1'b0, 32'h0, 20'h0FFFF}},
    '{rbol_pkg::CMD_FIND, 16'h0000, 32'h0000_0000, 20'h0FFFF, 1'b1,
      '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 32'h0, 20'h0FFFF}},
    '{rbol_pkg::CMD_FIND, 16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1,
      '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 32'h0, 20'h0FFFF}},
    // fill the remaining slots with full-size records
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_0002, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_0003, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_0004, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_0005, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_0006, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_0007, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_0008, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_0009, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_000A, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_000B, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_000C, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_000D, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_000E, 20'h00000, 1'b0, '0},
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'h0100_000F, 20'h00000, 1'b0, '0},
    // ring full: overwrite the oldest slot, reaching the largest total
    '{rbol_pkg::CMD_ADD, 16'hFFFF, 32'hA5A5_5A5A, 20'h00000, 1'b1,
      '{1'b0, 4'd0, 32'h0, 16'h0, 1'b1, 32'h0000_0000, 20'hFFFF0}},
    // last stored byte wraps to slot zero; the next one is beyond the data
    '{rbol_pkg::CMD_FIND, 16'h0000, 32'h0000_0000, 20'hFFFEF, 1'b1,
      '{1'b1, 4'd0, 32'hA5A5_5A5A, 16'hFFFE, 1'b0, 32'h0, 20'hFFFF0}},
    '{rbol_pkg::CMD_FIND, 16'h0000, 32'h0000_0000, 20'hFFFF0, 1'b1,
      '{1'b0, 4'd0, 32'h0, 16'h0, 1'b0, 32'h0, 20'hFFFF0}},
    // overwrite a full-size record with an empty one
    '{rbol_pkg::CMD_ADD, 16'h0000, 32'h0000_0000, 20'h00000, 1'b1,
      '{1'b0, 4'd0, 32'h0, 16'h0, 1'b1, 32'hFFFF_FFFF, 20'hEFFF1}}
  };

  // Sender idle rate of each random phase: none, heavy, light, none
  int unsigned phase_idle [4] = '{0, 69, 7, 0};

  ring_buffer_offset_lookup_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .entry_size_i     (entry_size_i),
    .entry_handle_i   (entry_handle_i),
    .char_offset_i    (char_offset_i),
    .done_o           (done_o),
    .found_o          (found_o),
    .slot_index_o     (slot_index_o),
    .found_handle_o   (found_handle_o),
    .byte_in_entry_o  (byte_in_entry_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_handle_o (evicted_handle_o),
    .total_bytes_o    (total_bytes_o)
  );

  // Generate the clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Advance a ring index with wrap
  function automatic logic [rbol_pkg::IDX_W-1:0] ring_step(
    input logic [rbol_pkg::IDX_W-1:0] i
  );
    return rbol_pkg::IDX_W'((int'(i) + 1) % rbol_pkg::DEPTH);
  endfunction

  // Apply one request to the local ring and return its response
  function automatic lookup_result_t compute_ring_response(
    input logic                        cmd,
    input logic [rbol_pkg::SIZE_W-1:0] size,
    input logic [rbol_pkg::HDL_W-1:0]  handle,
    input logic [rbol_pkg::TOT_W-1:0]  offset
  );
    lookup_result_t             r;
    logic [rbol_pkg::IDX_W-1:0] pos;
    logic [rbol_pkg::TOT_W-1:0] remain;
    r = '0;
    if (cmd == rbol_pkg::CMD_ADD) begin
      // drop the oldest record when full
      if (ring_is_full) begin
        r.ev_valid  = 1'b1;
        r.ev_handle = ring_handles[ring_wr];
        ring_total  = ring_total - rbol_pkg::TOT_W'(ring_lens[ring_wr]);
        ring_rd     = ring_step(ring_rd);
      end
      ring_handles[ring_wr] = handle;
      ring_lens[ring_wr]    = rbol_pkg::LEN_W'(size);
      ring_total            = ring_total + rbol_pkg::TOT_W'(size);
      ring_wr               = ring_step(ring_wr);
      ring_is_full          = (ring_wr == ring_rd);
    end else begin
      // walk from the oldest slot, consuming each record's length
      pos    = ring_rd;
      remain = offset;
      for (int k = 0; k < rbol_pkg::DEPTH; k++) begin
        if (!r.found) begin
          if (rbol_pkg::TOT_W'(ring_lens[pos]) > remain) begin
            r.found   = 1'b1;
            r.slot    = pos;
            r.fhandle = ring_handles[pos];
            r.in_byte = rbol_pkg::LEN_W'(remain);
          end else begin
            remain = remain - rbol_pkg::TOT_W'(ring_lens[pos]);
            pos    = ring_step(pos);
          end
        end
      end
    end
    r.total = ring_total;
    return r;
  endfunction

  // Hold one request until the block takes it, then record its response
  task automatic issue_request(
    input logic                        cmd,
    input logic [rbol_pkg::SIZE_W-1:0] size,
    input logic [rbol_pkg::HDL_W-1:0]  handle,
    input logic [rbol_pkg::TOT_W-1:0]  offset,
    input bit                          typed,
    input lookup_result_t              want
  );
    lookup_result_t predicted;
    start_i        <= 1'b1;
    cmd_i          <= cmd;
    entry_size_i   <= size;
    entry_handle_i <= handle;
    char_offset_i  <= offset;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    predicted = compute_ring_response(cmd, size, handle, offset);
    due_responses.push_back(typed ? want : predicted);
  endtask

  // Idle the request side at the current rate, driving noise meanwhile
  task automatic idle_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i        <= 1'b0;
      cmd_i          <= 1'($urandom);
      entry_size_i   <= rbol_pkg::SIZE_W'($urandom);
      entry_handle_i <= $urandom;
      char_offset_i  <= rbol_pkg::TOT_W'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Report one field mismatch
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Stimulus: directed table, then random phases
  initial begin
    logic                        cmd;
    logic [rbol_pkg::SIZE_W-1:0] size;
    logic [rbol_pkg::TOT_W-1:0]  offset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      issue_request(dir_rows[i].cmd, dir_rows[i].size, dir_rows[i].handle,
                    dir_rows[i].offset, dir_rows[i].typed, dir_rows[i].want);
    end

    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        idle_gap();
        cmd = 1'($urandom_range(0, 1));
        // favor short records so finds cross many slots
        case ($urandom_range(0, 9))
          0, 1, 2, 3: size = rbol_pkg::SIZE_W'($urandom_range(0, 7));
          4, 5, 6:    size = rbol_pkg::SIZE_W'($urandom_range(0, 255));
          7:          size = '1;
          default:    size = rbol_pkg::SIZE_W'($urandom);
        endcase
        // mostly offsets inside the data, plus the boundaries and noise
        case ($urandom_range(0, 9))
          7:       offset = ring_total;
          8:       offset = ring_total - 1'b1;
          9:       offset = rbol_pkg::TOT_W'($urandom);
          default: offset = rbol_pkg::TOT_W'($urandom_range(0, ring_total));
        endcase
        issue_request(cmd, size, $urandom, offset, 1'b0, '0);
      end
    end

    // Drain outstanding responses, then let the block settle
    start_i <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk_i);
    repeat (rbol_pkg::DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Check each response against the oldest prediction
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (due_responses.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual total %0h",
                 $time, total_bytes_o);
        mismatch_count++;
      end else begin
        want = due_responses.pop_front();
        check_field("found", 32'(want.found), 32'(found_o));
        check_field("slot_index", 32'(want.slot), 32'(slot_index_o));
        check_field("found_handle", want.fhandle, found_handle_o);
        check_field("byte_in_entry", 32'(want.in_byte), 32'(byte_in_entry_o));
        check_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid_o));
        check_field("evicted_handle", want.ev_handle, evicted_handle_o);
        check_field("total_bytes", 32'(want.total), 32'(total_bytes_o));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
